// ===== src/psv_pkg.sv =====
// shared constants, types and helpers for the plucked string voice
`default_nettype none
package psv_pkg;

  // delay line geometry and note tail
  localparam int MAX_PERIOD   = 2048;
  localparam int TAIL_SAMPLES = 1000;
  localparam int ADDR_W       = $clog2(MAX_PERIOD);

  // fixed field widths
  localparam int PERIOD_W   = 12;
  localparam int DURATION_W = 24;
  localparam int SAMPLE_W   = 16;
  localparam int REMAIN_W   = DURATION_W + 1;

  // noise generator
  localparam logic [SAMPLE_W-1:0] SEED_RESET = 16'd44257;
  localparam logic [SAMPLE_W-1:0] LFSR_TAPS  = 16'hB400;

  // item operation codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // one item as it leaves the front stage
  typedef struct packed {
    logic                start;
    logic                sound;
    logic                first;
    logic                last;
    logic [SAMPLE_W-1:0] noise;
    logic [ADDR_W-1:0]   addr;
  } tick_t;

  // galois lfsr, shift right, taps on the bit shifted out
  function automatic logic [SAMPLE_W-1:0] lfsr_next(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

  // halve a signed value, rounding toward zero
  function automatic logic signed [SAMPLE_W-1:0] half_trunc(
    input logic signed [SAMPLE_W-1:0] a
  );
    logic signed [SAMPLE_W-1:0] r;
    r = a >>> 1;
    if (a[SAMPLE_W-1] && a[0]) begin
      r = r + SAMPLE_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/psv_delay_ram.sv =====
// delay line storage: one write port, one registered read port
`default_nettype none
module psv_delay_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [psv_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [psv_pkg::SAMPLE_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [psv_pkg::ADDR_W-1:0]    rd_addr,
  output logic [psv_pkg::SAMPLE_W-1:0]  rd_data
);
  import psv_pkg::*;

  logic [SAMPLE_W-1:0] mem [MAX_PERIOD];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/psv_front.sv =====
// note state: cursor, pass flag, noise lfsr, sample count and seed register
`default_nettype none
module psv_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            operation,
  input  logic [psv_pkg::PERIOD_W-1:0]    period,
  input  logic [psv_pkg::DURATION_W-1:0]  duration,
  input  logic                            cfg_write,
  input  logic [psv_pkg::SAMPLE_W-1:0]    cfg_seed,
  output psv_pkg::tick_t                  tick,
  output logic [psv_pkg::ADDR_W-1:0]      rd_addr
);
  import psv_pkg::*;

  logic [SAMPLE_W-1:0] seed;
  logic [ADDR_W-1:0]   cursor;
  logic [PERIOD_W-1:0] note_period;
  logic [REMAIN_W-1:0] remaining;
  logic                first_pass;
  logic [SAMPLE_W-1:0] noise_state;
  logic                sounding;

  logic [PERIOD_W-1:0] period_clamped;
  logic [PERIOD_W-1:0] cursor_inc;
  logic [REMAIN_W-1:0] remaining_next;
  logic                is_start;

  assign is_start = (op_t'(operation) == OP_START);

  // describe the item for the next stage
  always_comb begin
    tick.start = is_start;
    tick.sound = !is_start && sounding;
    tick.first = first_pass;
    tick.last  = (remaining == REMAIN_W'(1));
    tick.noise = noise_state;
    tick.addr  = cursor;
  end

  assign rd_addr = cursor;

  // period clamp and cursor step
  always_comb begin
    period_clamped = period;
    if (period < PERIOD_W'(2)) begin
      period_clamped = PERIOD_W'(2);
    end else if (period > PERIOD_W'(MAX_PERIOD)) begin
      period_clamped = PERIOD_W'(MAX_PERIOD);
    end
    cursor_inc     = PERIOD_W'(cursor) + PERIOD_W'(1);
    remaining_next = REMAIN_W'(duration) + REMAIN_W'(TAIL_SAMPLES);
  end

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_write) begin
      seed <= cfg_seed;
    end
  end

  // note state update per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor      <= '0;
      note_period <= PERIOD_W'(2);
      remaining   <= '0;
      first_pass  <= 1'b1;
      noise_state <= SEED_RESET;
      sounding    <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        note_period <= period_clamped;
        cursor      <= '0;
        first_pass  <= 1'b1;
        noise_state <= seed;
        remaining   <= remaining_next;
        sounding    <= (remaining_next != '0);
      end else if (sounding) begin
        if (first_pass) begin
          noise_state <= lfsr_next(noise_state);
        end
        if (cursor_inc >= note_period) begin
          cursor     <= '0;
          first_pass <= 1'b0;
        end else begin
          cursor <= cursor_inc[ADDR_W-1:0];
        end
        remaining <= remaining - REMAIN_W'(1);
        if (remaining == REMAIN_W'(1)) begin
          sounding <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/psv_filter.sv =====
// averaging stage, delay line write back and result register
`default_nettype none
module psv_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  psv_pkg::tick_t                tick,
  input  logic [psv_pkg::SAMPLE_W-1:0]  rd_data,
  output logic                          take,
  output logic                          wr_en,
  output logic [psv_pkg::ADDR_W-1:0]    wr_addr,
  output logic [psv_pkg::SAMPLE_W-1:0]  wr_data,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [psv_pkg::SAMPLE_W-1:0]  sample,
  output logic                          active,
  output logic                          last
);
  import psv_pkg::*;

  logic                       hold_valid;
  tick_t                      hold;
  logic [SAMPLE_W-1:0]        previous_sample;
  logic                       advance;
  logic signed [SAMPLE_W-1:0] entry;
  logic signed [SAMPLE_W-1:0] new_value;

  // hold stage moves on when the result register frees up
  assign advance = hold_valid && (!result_valid || result_ready);
  assign take    = !hold_valid || advance;

  // new = entry/2 + previous/2, both toward zero
  always_comb begin
    entry     = hold.first ? hold.noise : rd_data;
    new_value = half_trunc(entry) + half_trunc(previous_sample);
  end

  assign wr_en   = advance && hold.sound;
  assign wr_addr = hold.addr;
  assign wr_data = new_value;

  // hold stage, waits for the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take) begin
      hold <= tick;
    end
  end

  // previous sample feeds the next item's average
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
    end else if (advance) begin
      if (hold.start) begin
        previous_sample <= '0;
      end else if (hold.sound) begin
        previous_sample <= new_value;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample <= hold.sound ? new_value : '0;
      active <= hold.sound;
      last   <= hold.sound && hold.last;
    end
  end

endmodule
`default_nettype wire

// ===== src/plucked_string_voice_top.sv =====
// plucked string voice: top level
//
// One Karplus-Strong voice. Items come in on item_valid/item_ready:
// operation selects a note start (period, duration) or one sample tick.
// Every item gives exactly one result on result_valid/result_ready with
// sample, active and last; a start or a tick while silent gives zeros.
// The noise seed is written over cfg_valid/cfg_ready with noise_seed,
// always ready, and should only change while the voice is idle.
// An accepted item passes through the delay line read and hold stage,
// then the average and the result register. Throughput: one item per
// clock while results are taken, limited by the single read and
// single write port of the delay line memory.
// When the receiver stalls, the result register holds and one more item
// waits in the read stage; item_ready then drops until the result is
// taken. Reset clears all control state and loads the seed reset value;
// the delay line itself is not cleared, since the first pass round it
// uses noise and writes each entry before it is read.
`default_nettype none
module plucked_string_voice_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic                            operation,
  input  logic [psv_pkg::PERIOD_W-1:0]    period,
  input  logic [psv_pkg::DURATION_W-1:0]  duration,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic signed [psv_pkg::SAMPLE_W-1:0] sample,
  output logic                            active,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psv_pkg::SAMPLE_W-1:0]    noise_seed
);
  import psv_pkg::*;

  logic                accept;
  tick_t               tick;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic [SAMPLE_W-1:0] sample_bits;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && item_ready;
  assign sample    = sample_bits;

  // note state and seed
  psv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .period    (period),
    .duration  (duration),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_seed  (noise_seed),
    .tick      (tick),
    .rd_addr   (rd_addr)
  );

  // delay line
  psv_delay_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // averaging and result
  psv_filter u_filter (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .tick         (tick),
    .rd_data      (rd_data),
    .take         (item_ready),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample       (sample_bits),
    .active       (active),
    .last         (last)
  );

endmodule
`default_nettype wire

// ===== test/plucked_string_voice_checker.sv =====
// checker for the plucked string voice: watches the channels, predicts and compares results
module plucked_string_voice_checker
  import psv_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_ready,
  input  logic                       operation,
  input  logic [PERIOD_W-1:0]        period,
  input  logic [DURATION_W-1:0]      duration,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       active,
  input  logic                       last,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [SAMPLE_W-1:0]        noise_seed,
  output int                         failures,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted result item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
    logic                       last;
  } voice_out_t;

  voice_out_t expected_q[$];

  // predicted voice state
  logic [SAMPLE_W-1:0] string_mem [MAX_PERIOD];
  logic [SAMPLE_W-1:0] prev_out;
  logic [ADDR_W-1:0]   pos;
  logic [PERIOD_W-1:0] note_len;
  logic [REMAIN_W-1:0] ring_left;
  logic                first_round;
  logic [SAMPLE_W-1:0] noise;
  logic [SAMPLE_W-1:0] seed;
  logic                sounding;

  // advance the predicted voice by one item and return its result
  function automatic voice_out_t pluck_step(input op_t op, input logic [PERIOD_W-1:0] per,
                                            input logic [DURATION_W-1:0] dur);
    voice_out_t          r;
    int                  entry;
    int                  mixed;
    logic [SAMPLE_W-1:0] word;
    logic [PERIOD_W-1:0] nxt;
    r = '0;
    if (op == OP_START) begin
      // load a new note, clamping the period into the delay line
      if (per < 2) note_len = PERIOD_W'(2);
      else if (per > MAX_PERIOD) note_len = PERIOD_W'(MAX_PERIOD);
      else note_len = per;
      pos = '0;
      prev_out = '0;
      first_round = 1'b1;
      noise = seed;
      ring_left = REMAIN_W'(dur) + REMAIN_W'(TAIL_SAMPLES);
      sounding = (ring_left != '0);
    end else if (sounding) begin
      // first round reads noise, later rounds read the line
      if (first_round) begin
        entry = int'($signed(noise));
        noise = {1'b0, noise[SAMPLE_W-1:1]} ^ (noise[0] ? LFSR_TAPS : '0);
      end else begin
        entry = int'($signed(string_mem[pos]));
      end
      // average with the previous output, each half toward zero
      mixed = entry / 2 + int'($signed(prev_out)) / 2;
      word = mixed[SAMPLE_W-1:0];
      string_mem[pos] = word;
      prev_out = word;
      nxt = PERIOD_W'(pos) + PERIOD_W'(1);
      if (nxt >= note_len) begin
        nxt = '0;
        first_round = 1'b0;
      end
      pos = nxt[ADDR_W-1:0];
      ring_left = ring_left - REMAIN_W'(1);
      r.sample = word;
      r.active = 1'b1;
      if (ring_left == '0) begin
        r.last = 1'b1;
        sounding = 1'b0;
      end
    end
    return r;
  endfunction

  // track config, predict on accepted items, compare accepted results
  always @(posedge clk) begin
    voice_out_t want;
    if (rst) begin
      prev_out = '0;
      pos = '0;
      note_len = PERIOD_W'(2);
      ring_left = '0;
      first_round = 1'b1;
      seed = SEED_RESET;
      noise = SEED_RESET;
      sounding = 1'b0;
      expected_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed = noise_seed;
      end
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          failures++;
          $error("result item with none expected: sample %0d active %0b last %0b",
                 sample, active, last);
        end else begin
          want = expected_q.pop_front();
          if (sample !== want.sample) begin
            failures++;
            $error("sample mismatch: expected %0d, got %0d", want.sample, sample);
          end
          if (active !== want.active) begin
            failures++;
            $error("active mismatch: expected %0b, got %0b", want.active, active);
          end
          if (last !== want.last) begin
            failures++;
            $error("last mismatch: expected %0b, got %0b", want.last, last);
          end
        end
      end
      if (item_valid && item_ready) begin
        expected_q.push_back(pluck_step(op_t'(operation), period, duration));
      end
      outstanding <= expected_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// testbench top for the plucked string voice: clock, reset, stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psv_pkg::*;

  localparam int HOLD_CYCLES = 200;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       item_valid;
  logic                       item_ready;
  logic                       operation;
  logic [PERIOD_W-1:0]        period;
  logic [DURATION_W-1:0]      duration;
  logic                       result_valid;
  logic                       result_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       active;
  logic                       last;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [SAMPLE_W-1:0]        noise_seed;
  int                         failures;
  int                         outstanding;

  // no gaps on either side while set
  logic calm;
  // each flip asks the receiver for one long hold-off
  logic hold_flip;
  int   items_sent;

  plucked_string_voice_top u_top (.*);
  plucked_string_voice_checker u_check (.*);

  always #5 clk = ~clk;

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // offer one item and wait until it is taken
  task automatic send_item(input op_t op, input logic [PERIOD_W-1:0] per,
                           input logic [DURATION_W-1:0] dur);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    period <= per;
    duration <= dur;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  // one note start followed by a run of ticks
  task automatic play(input logic [PERIOD_W-1:0] per, input logic [DURATION_W-1:0] dur,
                      input int ticks);
    send_item(OP_START, per, dur);
    repeat (ticks) send_item(OP_TICK, PERIOD_W'($urandom_range(0, 4095)),
                             DURATION_W'($urandom()));
  endtask

  // stop sending, let every result come back, then load a new seed
  task automatic retune(input logic [SAMPLE_W-1:0] value);
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    noise_seed <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SAMPLE_W'(1);
      2: return '1;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin : result_sink
    logic hold_seen;
    hold_seen = 1'b0;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_flip != hold_seen) begin
        hold_seen = hold_flip;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int                  start_mark;
    int                  phase_mark;
    int                  pick;
    int                  eff;
    int                  lim;
    int                  dur_short;
    logic [PERIOD_W-1:0]   per;
    logic [DURATION_W-1:0] dur;
    items_sent = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    operation <= OP_START;
    period <= '0;
    duration <= '0;
    cfg_valid <= 1'b0;
    noise_seed <= '0;
    calm <= 1'b0;
    hold_flip <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, clamped periods, extreme durations, reset seed
    send_item(OP_TICK, '1, '1);
    play(PERIOD_W'(0), '0, 5);
    play(PERIOD_W'(1), '1, 2);
    play('1, DURATION_W'(1), 2);
    play(PERIOD_W'(MAX_PERIOD), '0, 2);
    // zero seed gives silence
    retune('0);
    play(PERIOD_W'(5), DURATION_W'(10), 3);
    // all-ones seed, short line wrapping once
    retune('1);
    play(PERIOD_W'(3), '0, 5);

    // random notes, mostly well formed with short lines
    retune(pick_seed());
    start_mark = items_sent;
    phase_mark = items_sent;
    hold_flip <= ~hold_flip;
    while (items_sent - start_mark < 150) begin
      if (items_sent - phase_mark >= 50) begin
        retune(pick_seed());
        calm <= ($urandom_range(0, 3) == 0);
        phase_mark = items_sent;
      end
      if ($urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) per = PERIOD_W'($urandom_range(2, 40));
        else if (pick < 9) per = PERIOD_W'($urandom_range(0, 4095));
        else if ($urandom_range(0, 1) == 0) per = PERIOD_W'($urandom_range(0, 2));
        else per = PERIOD_W'($urandom_range(MAX_PERIOD - 1, MAX_PERIOD + 1));
        dur = ($urandom_range(0, 1) == 0) ? DURATION_W'($urandom())
                                          : DURATION_W'($urandom_range(0, 50));
        eff = (per < 2) ? 2 : (per > MAX_PERIOD) ? MAX_PERIOD : int'(per);
        lim = (3 * eff > 60) ? 60 : 3 * eff;
        play(per, dur, $urandom_range(1, lim));
      end else begin
        // noise: a lone item of either kind with random fields
        send_item(op_t'($urandom_range(0, 1)), PERIOD_W'($urandom_range(0, 4095)),
                  DURATION_W'($urandom()));
      end
    end

    // one full note to its final sample on a short line, with a long hold-off
    retune(SAMPLE_W'($urandom_range(1, 65535)));
    calm <= 1'b0;
    hold_flip <= ~hold_flip;
    dur_short = $urandom_range(0, 20);
    play(PERIOD_W'($urandom_range(2, 20)), DURATION_W'(dur_short),
         dur_short + TAIL_SAMPLES + 3);

    // drain and decide
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("** plucked_string_voice_top: PASSED **");
    end else begin
      $display("** plucked_string_voice_top: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #20_000_000;
    $display("** plucked_string_voice_top: FAILED **");
    $finish;
  end

endmodule
